### rtl/bpc_pkg.sv
package bpc_pkg;

   localparam int unsigned OVERSAMPLING = 3;
   localparam int unsigned DIV_DEPTH = 32;

   localparam logic [2:0] CSR_AC1_AC2 = 3'd0;
   localparam logic [2:0] CSR_AC3_AC4 = 3'd1;
   localparam logic [2:0] CSR_AC5_AC6 = 3'd2;
   localparam logic [2:0] CSR_B1_B2   = 3'd3;
   localparam logic [2:0] CSR_MC_MD   = 3'd4;

   localparam logic [31:0] B6_OFFSET  = 32'd4000;
   localparam logic [31:0] P_C1       = 32'd3038;
   localparam logic [31:0] P_C2       = 32'hFFFF_E343;
   localparam logic [31:0] P_C3       = 32'd3791;
   localparam logic [31:0] B7_SCALE   = 32'(50000 >> OVERSAMPLING);
   localparam logic [31:0] B4_OFFSET  = 32'd32768;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [18:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_tenths;
      logic signed [31:0] pressure_pa;
      logic               divide_error;
   } rsp_type;

endpackage

### rtl/barometric_pressure_compensation.sv
// throughput: one word per cycle unless a stalled rsp word holds the pipeline;
// the two 32-stage bit-serial dividers (temperature and pressure) set the
// latency, every stage takes a new word
// a stalled rsp word freezes the whole pipeline in place
// reset (synchronous, active high) clears all valid bits and the
// coefficient registers to zero
module barometric_pressure_compensation (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam int unsigned OSS = bpc_pkg::OVERSAMPLING;

   logic [31:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic        en;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= '0;
         ac3_ac4_ff <= '0;
         ac5_ac6_ff <= '0;
         b1_b2_ff   <= '0;
         mc_md_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            bpc_pkg::CSR_AC1_AC2: ac1_ac2_ff <= csr_data;
            bpc_pkg::CSR_AC3_AC4: ac3_ac4_ff <= csr_data;
            bpc_pkg::CSR_AC5_AC6: ac5_ac6_ff <= csr_data;
            bpc_pkg::CSR_B1_B2:   b1_b2_ff   <= csr_data;
            bpc_pkg::CSR_MC_MD:   mc_md_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign ac1 = {{16{ac1_ac2_ff[31]}}, ac1_ac2_ff[31:16]};
   assign ac2 = {{16{ac1_ac2_ff[15]}}, ac1_ac2_ff[15:0]};
   assign ac3 = {{16{ac3_ac4_ff[31]}}, ac3_ac4_ff[31:16]};
   assign ac4 = {16'd0, ac3_ac4_ff[15:0]};
   assign ac5 = {16'd0, ac5_ac6_ff[31:16]};
   assign ac6 = {16'd0, ac5_ac6_ff[15:0]};
   assign b1  = {{16{b1_b2_ff[31]}}, b1_b2_ff[31:16]};
   assign b2  = {{16{b1_b2_ff[15]}}, b1_b2_ff[15:0]};
   assign mc  = {{16{mc_md_ff[31]}}, mc_md_ff[31:16]};
   assign md  = {{16{mc_md_ff[15]}}, mc_md_ff[15:0]};

   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // stage 1: raw temperature product
   logic        v1_ff;
   logic [31:0] p1_ff;
   logic [18:0] up1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= 32'((32'(req_data.raw_temperature) - ac6) * ac5);
         up1_ff <= req_data.raw_pressure;
      end
   end

   // temperature divider feed
   logic [31:0] x1_t, den_t, num_t, mag_num_t, mag_den_t;
   logic        neg_t, zero_t;

   always_comb begin
      x1_t      = 32'($signed(p1_ff) >>> 15);
      den_t     = x1_t + md;
      num_t     = mc << 11;
      zero_t    = (den_t == 32'd0);
      neg_t     = num_t[31] ^ den_t[31];
      mag_num_t = num_t[31] ? 32'(-num_t) : num_t;
      mag_den_t = den_t[31] ? 32'(-den_t) : den_t;
   end

   logic        dv1_valid;
   logic [31:0] dv1_quo;
   logic [52:0] dv1_side;

   bpc_udiv #(.SIDE_W(53)) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_num    (mag_num_t),
      .in_den    (mag_den_t),
      .in_side   ({up1_ff, x1_t, neg_t, zero_t}),
      .out_valid (dv1_valid),
      .out_quo   (dv1_quo),
      .out_side  (dv1_side)
   );

   // stage 3: b5, temperature, b6
   logic [31:0] x2_t, b5, t_sum, t_val;
   logic        v3_ff, err3_ff;
   logic [31:0] t3_ff, b63_ff;
   logic [18:0] up3_ff;

   always_comb begin
      x2_t  = dv1_side[1] ? 32'(-dv1_quo) : dv1_quo;
      b5    = dv1_side[33:2] + x2_t;
      t_sum = b5 + 32'd8;
      t_val = 32'($signed(t_sum[31] ? t_sum + 32'd15 : t_sum) >>> 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= dv1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_ff   <= t_val;
         b63_ff  <= b5 - bpc_pkg::B6_OFFSET;
         up3_ff  <= dv1_side[52:34];
         err3_ff <= dv1_side[0];
      end
   end

   // stage 4: b6 products
   logic        v4_ff, err4_ff;
   logic [31:0] t4_ff, sqp4_ff, a24_ff, a34_ff;
   logic [18:0] up4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqp4_ff <= 32'(b63_ff * b63_ff);
         a24_ff  <= 32'(ac2 * b63_ff);
         a34_ff  <= 32'(ac3 * b63_ff);
         t4_ff   <= t3_ff;
         up4_ff  <= up3_ff;
         err4_ff <= err3_ff;
      end
   end

   // stage 5: square products
   logic [31:0] sq5;
   logic        v5_ff, err5_ff;
   logic [31:0] t5_ff, mb25_ff, mb15_ff, xa5_ff, xc5_ff;
   logic [18:0] up5_ff;

   assign sq5 = 32'($signed(sqp4_ff) >>> 12);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mb25_ff <= 32'(b2 * sq5);
         mb15_ff <= 32'(b1 * sq5);
         xa5_ff  <= 32'($signed(a24_ff) >>> 11);
         xc5_ff  <= 32'($signed(a34_ff) >>> 13);
         t5_ff   <= t4_ff;
         up5_ff  <= up4_ff;
         err5_ff <= err4_ff;
      end
   end

   // stage 6: b3 and x3
   logic [31:0] x3_a, b3_sum, x3_b;
   logic        v6_ff, err6_ff;
   logic [31:0] t6_ff, b36_ff, x36_ff;
   logic [18:0] up6_ff;

   always_comb begin
      x3_a   = 32'($signed(mb25_ff) >>> 11) + xa5_ff;
      b3_sum = ((32'(ac1 << 2) + x3_a) << OSS) + 32'd2;
      x3_b   = xc5_ff + 32'($signed(mb15_ff) >>> 16) + 32'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b36_ff  <= 32'($signed(b3_sum) >>> 2);
         x36_ff  <= 32'($signed(x3_b) >>> 2);
         t6_ff   <= t5_ff;
         up6_ff  <= up5_ff;
         err6_ff <= err5_ff;
      end
   end

   // stage 7: b4 product and b7
   logic        v7_ff, err7_ff;
   logic [31:0] t7_ff, m47_ff, b77_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m47_ff  <= 32'(ac4 * (x36_ff + bpc_pkg::B4_OFFSET));
         b77_ff  <= 32'((32'(up6_ff) - b36_ff) * bpc_pkg::B7_SCALE);
         t7_ff   <= t6_ff;
         err7_ff <= err6_ff;
      end
   end

   // pressure divider feed
   logic [31:0] b4, num_p;
   logic        err_p;

   always_comb begin
      b4    = m47_ff >> 15;
      err_p = err7_ff || (b4 == 32'd0);
      num_p = b77_ff[31] ? b77_ff : (b77_ff << 1);
   end

   logic        dv2_valid;
   logic [31:0] dv2_quo;
   logic [33:0] dv2_side;

   bpc_udiv #(.SIDE_W(34)) u_div_press (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .in_num    (num_p),
      .in_den    (b4),
      .in_side   ({t7_ff, b77_ff[31], err_p}),
      .out_valid (dv2_valid),
      .out_quo   (dv2_quo),
      .out_side  (dv2_side)
   );

   // stage 9: pressure polynomial products
   logic [31:0] p_raw, pa;
   logic        v9_ff, err9_ff;
   logic [31:0] t9_ff, p9_ff, pp9_ff, mx9_ff;

   always_comb begin
      p_raw = dv2_side[1] ? (dv2_quo << 1) : dv2_quo;
      pa    = 32'($signed(p_raw) >>> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= dv2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp9_ff  <= 32'(pa * pa);
         mx9_ff  <= 32'(bpc_pkg::P_C2 * p_raw);
         p9_ff   <= p_raw;
         t9_ff   <= dv2_side[33:2];
         err9_ff <= dv2_side[0];
      end
   end

   // stage 10
   logic        v10_ff, err10_ff;
   logic [31:0] t10_ff, p10_ff, m310_ff, x210_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m310_ff  <= 32'(pp9_ff * bpc_pkg::P_C1);
         x210_ff  <= 32'($signed(mx9_ff) >>> 16);
         p10_ff   <= p9_ff;
         t10_ff   <= t9_ff;
         err10_ff <= err9_ff;
      end
   end

   // output word
   logic [31:0]      corr_sum, p_final;
   bpc_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      corr_sum = 32'($signed(m310_ff) >>> 16) + x210_ff + bpc_pkg::P_C3;
      p_final  = p10_ff + 32'($signed(corr_sum) >>> 4);
      if (err10_ff) begin
         rsp_in.temperature_tenths = '0;
         rsp_in.pressure_pa        = '0;
         rsp_in.divide_error       = 1'b1;
      end else begin
         rsp_in.temperature_tenths = t10_ff;
         rsp_in.pressure_pa        = p_final;
         rsp_in.divide_error       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   property p_err_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_data.divide_error) |->
            (rsp_data.temperature_tenths == 0 && rsp_data.pressure_pa == 0);
   endproperty
   a_err_zero: assert property (p_err_zero) else $error("error word not zeroed");

   property p_stall_rule;
      @(posedge clock) req_stall == (rsp_valid && rsp_stall);
   endproperty
   a_stall_rule: assert property (p_stall_rule) else $error("stall mismatch");

   property p_freeze;
      @(posedge clock) disable iff (reset)
         req_stall |=> ($stable(v7_ff) && $stable(v3_ff) && $stable(b77_ff));
   endproperty
   a_freeze: assert property (p_freeze) else $error("pipeline moved while stalled");

endmodule

### rtl/bpc_udiv.sv
module bpc_udiv #(
   parameter int unsigned SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         in_num,
   input  logic [31:0]         in_den,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [31:0]         out_quo,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int unsigned DEPTH = bpc_pkg::DIV_DEPTH;

   logic              valid_ff [DEPTH];
   logic [31:0]       rem_ff   [DEPTH];
   logic [31:0]       num_ff   [DEPTH];
   logic [31:0]       den_ff   [DEPTH];
   logic [SIDE_W-1:0] side_ff  [DEPTH];

   logic [31:0]       rem_in   [DEPTH];
   logic [31:0]       num_in   [DEPTH];

   always_comb begin
      logic [31:0] rem_src;
      logic [31:0] num_src;
      logic [31:0] den_src;
      logic [32:0] shifted;
      for (int i = 0; i < DEPTH; i++) begin
         rem_src = (i == 0) ? 32'd0 : rem_ff[(i == 0) ? 0 : i - 1];
         num_src = (i == 0) ? in_num : num_ff[(i == 0) ? 0 : i - 1];
         den_src = (i == 0) ? in_den : den_ff[(i == 0) ? 0 : i - 1];
         shifted = {rem_src, num_src[31]};
         if (shifted >= {1'b0, den_src}) begin
            rem_in[i] = 32'(shifted - {1'b0, den_src});
            num_in[i] = {num_src[30:0], 1'b1};
         end else begin
            rem_in[i] = shifted[31:0];
            num_in[i] = {num_src[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int i = 1; i < DEPTH; i++) begin
            den_ff[i]  <= den_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
         for (int i = 0; i < DEPTH; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_in[i];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_quo   = num_ff[DEPTH-1];
   assign out_side  = side_ff[DEPTH-1];

endmodule

### bench/tb.sv
module tb;

   localparam logic [2:0] CSR_UNMAPPED = 3'd5;
   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 80;

   typedef logic [31:0] coef_set_type [5];

   typedef struct {
      int               set_id;
      logic [15:0]      ut;
      logic [18:0]      up;
      bit               typed;
      bpc_pkg::rsp_type known;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   bpc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   bpc_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   logic [31:0] coef [5];
   bpc_pkg::rsp_type expected_readings [$];
   int mismatch_count = 0;
   int readings_seen = 0;
   int error_readings = 0;
   int cycle_count = 0;
   bit sender_idles = 1;
   bit receiver_idles = 1;
   int stall_left = 0;

   coef_set_type directed_sets [3];
   stim_row_type directed_rows [$];

   barometric_pressure_compensation uut (.*);

   always #5 clock = ~clock;

   function automatic logic [31:0] asr(logic [31:0] v, int s);
      return $unsigned($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] sext16(logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? 32'd0 - a : a;
      mb = b[31] ? 32'd0 - b : b;
      q = ma / mb;
      return (a[31] ^ b[31]) ? 32'd0 - q : q;
   endfunction

   function automatic bpc_pkg::rsp_type compensate(logic [15:0] raw_t, logic [18:0] raw_p);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, dv;
      bpc_pkg::rsp_type r;
      r = '0;
      r.divide_error = 1;
      ac1 = sext16(coef[0][31:16]);
      ac2 = sext16(coef[0][15:0]);
      ac3 = sext16(coef[1][31:16]);
      ac4 = {16'd0, coef[1][15:0]};
      ac5 = {16'd0, coef[2][31:16]};
      ac6 = {16'd0, coef[2][15:0]};
      b1 = sext16(coef[3][31:16]);
      b2 = sext16(coef[3][15:0]);
      mc = sext16(coef[4][31:16]);
      md = sext16(coef[4][15:0]);
      ut = {16'd0, raw_t};
      up = {13'd0, raw_p};
      x1 = asr((ut - ac6) * ac5, 15);
      dv = x1 + md;
      if (dv == 0) return r;
      x2 = trunc_div(mc << 11, dv);
      b5 = x1 + x2;
      t = trunc_div(b5 + 32'd8, 32'd16);
      b6 = b5 - bpc_pkg::B6_OFFSET;
      sq = asr(b6 * b6, 12);
      x1 = asr(b2 * sq, 11);
      x2 = asr(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = asr(((ac1 * 32'd4 + x3) << bpc_pkg::OVERSAMPLING) + 32'd2, 2);
      x1 = asr(ac3 * b6, 13);
      x2 = asr(b1 * sq, 16);
      x3 = asr(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + bpc_pkg::B4_OFFSET)) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * bpc_pkg::B7_SCALE;
      if (!b7[31]) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = asr(p, 8) * asr(p, 8);
      x1 = asr(x1 * bpc_pkg::P_C1, 16);
      x2 = asr(bpc_pkg::P_C2 * p, 16);
      p = p + asr(x1 + x2 + bpc_pkg::P_C3, 4);
      r.temperature_tenths = t;
      r.pressure_pa = p;
      r.divide_error = 0;
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: check accepted words, draw stalls
   always @(posedge clock) begin
      bpc_pkg::rsp_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         readings_seen <= readings_seen + 1;
         if (expected_readings.size() == 0) begin
            $display("%0t unexpected word %h", $time, rsp_data);
            mismatch_count = mismatch_count + 1;
         end else begin
            exp_w = expected_readings.pop_front();
            if (exp_w.divide_error) error_readings <= error_readings + 1;
            if (rsp_data.temperature_tenths !== exp_w.temperature_tenths) begin
               $display("%0t temperature_tenths expected %0d actual %0d", $time,
                        exp_w.temperature_tenths, rsp_data.temperature_tenths);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_data.pressure_pa !== exp_w.pressure_pa) begin
               $display("%0t pressure_pa expected %0d actual %0d", $time,
                        exp_w.pressure_pa, rsp_data.pressure_pa);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_data.divide_error !== exp_w.divide_error) begin
               $display("%0t divide_error expected %b actual %b", $time,
                        exp_w.divide_error, rsp_data.divide_error);
               mismatch_count = mismatch_count + 1;
            end
         end
         stall_left = receiver_idles ? $urandom_range(0, 6) : 0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send_word(logic [15:0] ut, logic [18:0] up, bit typed,
                            bpc_pkg::rsp_type known);
      int gap;
      bpc_pkg::rsp_type w;
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{raw_temperature: ut, raw_pressure: up};
      do @(posedge clock); while (req_stall);
      w = compensate(ut, up);
      if (typed && w !== known)
         $display("%0t directed row disagrees with predictor: %h vs %h", $time, known, w);
      expected_readings.push_back(typed ? known : w);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_coefs(coef_set_type s, bit poke_unmapped);
      logic [2:0] idx [5] = '{bpc_pkg::CSR_AC1_AC2, bpc_pkg::CSR_AC3_AC4,
                              bpc_pkg::CSR_AC5_AC6, bpc_pkg::CSR_B1_B2,
                              bpc_pkg::CSR_MC_MD};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1;
         csr_index <= idx[i];
         csr_data <= s[i];
         do @(posedge clock); while (!csr_ready);
         coef[i] = s[i];
      end
      if (poke_unmapped) begin
         csr_index <= CSR_UNMAPPED;
         csr_data <= $urandom;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] jitter(int base, int span);
      return 16'(base + $urandom_range(0, 2 * span) - span);
   endfunction

   initial begin
      coef_set_type s;
      bpc_pkg::rsp_type err_w;
      int cur_set;
      int kind;
      logic [15:0] ut;
      logic [18:0] up;
      err_w = '0;
      err_w.divide_error = 1;
      for (int i = 0; i < 5; i++) coef[i] = '0;
      directed_sets[0] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      // nonzero md, zero ac4: pressure divisor is zero
      directed_sets[1] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0001};
      directed_sets[2] = '{{16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741},
                           {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                           {16'hDDF9, 16'd2868}};
      // zero coefficients: temperature divisor is zero
      directed_rows.push_back('{0, 16'h0000, 19'h00000, 1, err_w});
      directed_rows.push_back('{0, 16'hFFFF, 19'h7FFFF, 1, err_w});
      directed_rows.push_back('{0, 16'h8000, 19'h40000, 1, err_w});
      directed_rows.push_back('{1, 16'h0000, 19'h7FFFF, 1, err_w});
      directed_rows.push_back('{1, 16'hFFFF, 19'h00000, 1, err_w});
      directed_rows.push_back('{1, 16'd27898, 19'd190744, 1, err_w});
      directed_rows.push_back('{2, 16'd27898, 19'd23843 << 3, 0, err_w});
      directed_rows.push_back('{2, 16'd27898, 19'd190744, 0, err_w});
      directed_rows.push_back('{2, 16'h0000, 19'h00000, 0, err_w});
      directed_rows.push_back('{2, 16'hFFFF, 19'h7FFFF, 0, err_w});
      directed_rows.push_back('{2, 16'h0000, 19'h7FFFF, 0, err_w});
      directed_rows.push_back('{2, 16'hFFFF, 19'h00000, 0, err_w});
      directed_rows.push_back('{2, 16'd23153, 19'd200000, 0, err_w});
      directed_rows.push_back('{2, 16'h5555, 19'h2AAAA, 0, err_w});
      directed_rows.push_back('{2, 16'hAAAA, 19'h55555, 0, err_w});

      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      cur_set = 0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_id != cur_set) begin
            drain();
            cur_set = directed_rows[i].set_id;
            load_coefs(directed_sets[cur_set], cur_set == 2);
         end
         send_word(directed_rows[i].ut, directed_rows[i].up, directed_rows[i].typed,
                   directed_rows[i].known);
      end

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         kind = ph % 3;
         for (int i = 0; i < 5; i++) begin
            case (kind)
               0: s[i] = $urandom;
               1: s[i] = (ph == 1) ? 32'hFFFF_FFFF : 32'h0000_0000 | $urandom_range(0, 3);
               default: s[i] = directed_sets[2][i];
            endcase
         end
         if (kind == 2) begin
            s[0] = {jitter(408, 2000), jitter(-72, 500)};
            s[1] = {jitter(-14383, 3000), jitter(32741, 2000)};
            s[2] = {jitter(32757, 2000), jitter(23153, 2000)};
            s[3] = {jitter(6190, 1000), jitter(4, 50)};
            s[4] = {jitter(-8711, 1000), jitter(2868, 500)};
         end
         load_coefs(s, ph % 2 == 0);
         sender_idles = (ph != 3);
         receiver_idles = (ph != 4);
         for (int n = 0; n < 72; n++) begin
            if ($urandom_range(0, 3) != 0) begin
               ut = jitter(27898, 6000);
               up = 19'($urandom_range(120000, 260000));
            end else begin
               ut = 16'($urandom);
               up = 19'($urandom);
            end
            send_word(ut, up, 0, err_w);
         end
      end
      drain();
      $display("checked %0d readings (%0d with divide error) over 9 coefficient sets",
               readings_seen, error_readings);
      $display("directed extremes, both zero divisors, random and near-nominal inputs");
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
